// ===== sv/mcdm_pkg.sv =====
// Shared types and codes of the multichannel dematrix.
// Used by mcdm_regs, multichannel_dematrix, mcdm_checker and tb_top; depends on nothing else.
`default_nettype none
package mcdm_pkg;

	// Matrix modes after the channel count has been clamped.
	localparam logic [1:0] MODE_3CH = 2'd0;
	localparam logic [1:0] MODE_4CH = 2'd1;
	localparam logic [1:0] MODE_5CH = 2'd2;

	// Layout selectors at or above this value are undefined.
	localparam logic [3:0] NUM_LAYOUTS = 4'd12;

	// Register indexes as decoded from paddr[2].
	localparam logic REG_CHANNEL_COUNT = 1'b0;
	localparam logic REG_MATRIX_SELECT = 1'b1;

	// Item kinds carried in tuser on the input side.
	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_LINE = 1'b1;

	typedef struct packed {
		logic [2:0] channel_count;
		logic [3:0] matrix_select;
	} cfg_t;

endpackage
`default_nettype wire

// ===== sv/mcdm_regs.sv =====
// Configuration registers (APB) and coefficient store of the dematrix.
// Depends on mcdm_pkg for the register codes and the cfg_t struct.
`default_nettype none
module mcdm_regs #(
	parameter int MAX_CHANNELS = 5,
	parameter int COEF_BITS    = 16
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         psel,
	input  logic                                         penable,
	input  logic                                         pwrite,
	input  logic [2:0]                                   paddr,
	input  logic [31:0]                                  pwdata,
	output logic [31:0]                                  prdata,
	output logic                                         pready,
	input  logic                                         ld_en,
	input  logic [2:0]                                   ld_set,
	input  logic [1:0]                                   ld_pick,
	input  logic [COEF_BITS-1:0]                         ld_value,
	output logic [4*MAX_CHANNELS-1:0][COEF_BITS-1:0]     coef,
	output mcdm_pkg::cfg_t                               cfg
);

	localparam int NCOEF = 4 * MAX_CHANNELS;

	logic [NCOEF-1:0][COEF_BITS-1:0] store_q;
	mcdm_pkg::cfg_t                  cfg_q;
	logic                            wr_en;

	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.channel_count <= 3'd3;
			cfg_q.matrix_select <= 4'd0;
		end else if (wr_en) begin
			unique case (paddr[2])
				mcdm_pkg::REG_CHANNEL_COUNT: cfg_q.channel_count <= pwdata[2:0];
				mcdm_pkg::REG_MATRIX_SELECT: cfg_q.matrix_select <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	// Loads with a set index beyond the store are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			store_q <= '0;
		end else if (ld_en) begin
			for (int i = 0; i < NCOEF; i++) begin
				if ({29'd0, ld_set} == i / 4 && {30'd0, ld_pick} == i % 4) begin
					store_q[i] <= ld_value;
				end
			end
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[1:0] == 2'd0) begin
			unique case (paddr[2])
				mcdm_pkg::REG_CHANNEL_COUNT: prdata = {29'd0, cfg_q.channel_count};
				mcdm_pkg::REG_MATRIX_SELECT: prdata = {28'd0, cfg_q.matrix_select};
				default: prdata = '0;
			endcase
		end
	end

	assign coef = store_q;
	assign cfg  = cfg_q;

endmodule
`default_nettype wire

// ===== sv/multichannel_dematrix.sv =====
// Top level of the multichannel dematrix: six-stage matrix pipeline.
// Depends on mcdm_pkg and instantiates mcdm_regs.
//
// The block mixes one spectral line vector across 3, 4 or 5 channels.
// Input requests arrive on the s_ channel. s_tuser[0] is the kind: a load
// request writes at most one coefficient into the store and yields no result; a
// line request yields exactly one result on the m_ channel, carrying the
// five mixed lines in m_tdata and the undefined-selector flag in m_tuser.
// Channel count and layout selector are to be set through the APB port only
// while the block is idle; the block itself does not enforce this.
//
// A line request accepted into the first stage moves through the later stages
// in order up to the output register. Throughput is one request per cycle unless the receiver stalls.
// The six stages hold the coefficient products, the layout pick, the
// five-channel scaling, the entry-by-line multiply, the row sum and the
// saturation; the entry-by-line multiply is the deepest of them.
//
// Each stage holds its own valid bit and loads whenever it is empty or the
// stage after it moves, so bubbles fill up while the receiver stalls and
// s_tready drops only when every stage holds a result. Nothing is lost or
// repeated under a stall. Coefficients are snapshotted at acceptance, so
// later loads do not disturb lines already in flight.
//
// Reset clears the valid bits, the coefficient store (all zero), the
// channel count (three) and the layout selector (zero).
`default_nettype none
module multichannel_dematrix #(
	parameter int MAX_CHANNELS = 5,
	parameter int COEF_BITS    = 16,
	parameter int SAMPLE_BITS  = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [2:0]                   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// set_index, coef_pick, coef_value, line_ch0 .. line_ch4, zero pad
	input  logic [((5+COEF_BITS+5*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
	// func
	input  logic [0:0]                   s_tuser,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// mixed_ch0 .. mixed_ch4, zero pad
	output logic [((5*SAMPLE_BITS+7)/8)*8-1:0] m_tdata,
	// bad_select
	output logic [0:0]                   m_tuser
);

	localparam int NCOEF  = 4 * MAX_CHANNELS;
	localparam int CB     = COEF_BITS;
	localparam int SB     = SAMPLE_BITS;
	localparam int FRAC   = COEF_BITS - 3;
	localparam int TW     = CB + 3;            // three-channel entry
	localparam int MW     = CB + 6;            // any matrix entry
	localparam int PW     = MW + SB;           // entry times line
	localparam int AW     = PW + 3;            // five-term sum
	localparam int RW     = AW - FRAC;         // rounded sum
	localparam int LINE0  = 5 + CB;

	localparam logic signed [AW-1:0] HALF_A = {{(AW-FRAC){1'b0}}, 1'b1, {(FRAC-1){1'b0}}};
	localparam logic signed [RW-1:0] SAT_HI = {{(RW-SB+1){1'b0}}, {(SB-1){1'b1}}};
	localparam logic signed [RW-1:0] SAT_LO = {{(RW-SB+1){1'b1}}, {(SB-1){1'b0}}};

	// Store position of coefficient k of a set, wrapping past the store.
	function automatic int ci(input int s, input int k);
		return (s * 4 + k) % NCOEF;
	endfunction

	// Rounded product of two coefficients.
	function automatic logic signed [TW-1:0] rcc(input logic signed [CB-1:0] a,
		input logic signed [CB-1:0] b);
		logic signed [2*CB:0] p;
		p = a * b;
		p = p + {{(2*CB+1-FRAC){1'b0}}, 1'b1, {(FRAC-1){1'b0}}};
		return p[FRAC+TW-1:FRAC];
	endfunction

	// Rounded product of a coefficient and a three-channel entry.
	function automatic logic signed [MW-1:0] rct(input logic signed [CB-1:0] a,
		input logic signed [TW-1:0] b);
		logic signed [CB+TW:0] p;
		p = a * b;
		p = p + {{(CB+TW+1-FRAC){1'b0}}, 1'b1, {(FRAC-1){1'b0}}};
		return p[FRAC+MW-1:FRAC];
	endfunction

	// ---------------------------------------------------------------
	// Registers and coefficient store
	// ---------------------------------------------------------------
	logic [NCOEF-1:0][CB-1:0] coef;
	mcdm_pkg::cfg_t           cfg;
	logic                     in_req;
	logic                     ld_en;

	assign in_req = s_tvalid && s_tready;
	assign ld_en  = in_req && (s_tuser[0] == mcdm_pkg::FUNC_LOAD);

	mcdm_regs #(
		.MAX_CHANNELS(MAX_CHANNELS),
		.COEF_BITS   (COEF_BITS)
	) u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.ld_en   (ld_en),
		.ld_set  (s_tdata[2:0]),
		.ld_pick (s_tdata[4:3]),
		.ld_value(s_tdata[5+CB-1:5]),
		.coef    (coef),
		.cfg     (cfg)
	);

	// ---------------------------------------------------------------
	// Stage enables: a stage loads when empty or when its successor moves.
	// ---------------------------------------------------------------
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en1, en2, en3, en4, en5, en6;

	assign en6      = !v_s6 || m_tready;
	assign en5      = !v_s5 || en6;
	assign en4      = !v_s4 || en5;
	assign en3      = !v_s3 || en4;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign s_tready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_req && (s_tuser[0] == mcdm_pkg::FUNC_LINE);
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
		end
	end

	// ---------------------------------------------------------------
	// Stage 1: mode decode and the coefficient-by-coefficient products that the layouts and forms use.
	// ---------------------------------------------------------------
	logic [2:0]               ncl;
	logic [1:0]               mode_c;
	logic                     bad_c;
	logic signed [TW-1:0]     p3_c [8];
	logic signed [TW-1:0]     m4_c [4][4];
	logic signed [TW-1:0]     e5_c [8];

	always_comb begin
		if (cfg.channel_count < 3'd3) begin
			ncl = 3'd3;
		end else if (cfg.channel_count > 3'(MAX_CHANNELS)) begin
			ncl = 3'(MAX_CHANNELS);
		end else begin
			ncl = cfg.channel_count;
		end
		if (ncl == 3'd4) begin
			mode_c = mcdm_pkg::MODE_4CH;
		end else if (ncl == 3'd5) begin
			mode_c = mcdm_pkg::MODE_5CH;
		end else begin
			mode_c = mcdm_pkg::MODE_3CH;
		end
		bad_c = (mode_c != mcdm_pkg::MODE_4CH) && (cfg.matrix_select >= mcdm_pkg::NUM_LAYOUTS);
	end

	// Products used by the permutation layouts: u is set 0, v is set 1.
	always_comb begin
		p3_c[0] = rcc(coef[ci(0, 0)], coef[ci(1, 0)]);    // ua va
		p3_c[1] = rcc(coef[ci(0, 1)], coef[ci(1, 0)]);    // ub va
		p3_c[2] = rcc(coef[ci(0, 0)], coef[ci(1, 2)]);    // ua vc
		p3_c[3] = rcc(coef[ci(0, 1)], coef[ci(1, 2)]);    // ub vc
		p3_c[4] = rcc(coef[ci(0, 2)], coef[ci(1, 1)]);    // uc vb
		p3_c[5] = rcc(coef[ci(0, 3)], coef[ci(1, 1)]);    // ud vb
		p3_c[6] = rcc(coef[ci(0, 2)], coef[ci(1, 3)]);    // uc vd
		p3_c[7] = rcc(coef[ci(0, 3)], coef[ci(1, 3)]);    // ud vd
		// Extra columns of the five-channel form.
		e5_c[0] = rcc(coef[ci(3, 1)], coef[ci(2, 0)]);
		e5_c[1] = rcc(coef[ci(3, 1)], coef[ci(2, 1)]);
		e5_c[2] = rcc(coef[ci(4, 1)], coef[ci(2, 2)]);
		e5_c[3] = rcc(coef[ci(4, 1)], coef[ci(2, 3)]);
		e5_c[4] = rcc(coef[ci(3, 3)], coef[ci(2, 0)]);
		e5_c[5] = rcc(coef[ci(3, 3)], coef[ci(2, 1)]);
		e5_c[6] = rcc(coef[ci(4, 3)], coef[ci(2, 2)]);
		e5_c[7] = rcc(coef[ci(4, 3)], coef[ci(2, 3)]);
	end

	// Four-channel product form: row r pairs set (j/2) with set 2 + (r odd).
	always_comb begin
		for (int r = 0; r < 4; r++) begin
			for (int j = 0; j < 4; j++) begin
				m4_c[r][j] = rcc(coef[ci(j / 2, ((r % 2) * 2) + (j % 2))],
					coef[ci(2 + (r % 2), ((r / 2) * 2) + (j / 2))]);
			end
		end
	end

	logic [1:0]              mode_s1;
	logic                    bad_s1;
	logic [3:0]              sel_s1;
	logic signed [SB-1:0]    x_s1 [5];
	logic signed [CB-1:0]    cf_s1 [NCOEF];
	logic signed [TW-1:0]    p3_s1 [8];
	logic signed [TW-1:0]    m4_s1 [4][4];
	logic signed [TW-1:0]    e5_s1 [8];

	always_ff @(posedge clk) begin
		if (en1) begin
			mode_s1 <= mode_c;
			bad_s1  <= bad_c;
			sel_s1  <= cfg.matrix_select;
			for (int i = 0; i < 5; i++) begin
				x_s1[i] <= s_tdata[LINE0 + i*SB +: SB];
			end
			for (int i = 0; i < NCOEF; i++) begin
				cf_s1[i] <= coef[i];
			end
			p3_s1 <= p3_c;
			m4_s1 <= m4_c;
			e5_s1 <= e5_c;
		end
	end

	// ---------------------------------------------------------------
	// Stage 2: pick the three-channel layout.
	// ---------------------------------------------------------------
	logic signed [TW-1:0] t_c [3][3];
	logic signed [TW-1:0] ua, ub, uc, ud, va, vb, vc, vd;
	logic signed [TW-1:0] aa, ba, ac, bc, cb, db, cd, dd;

	always_comb begin
		ua = TW'(cf_s1[ci(0, 0)]);
		ub = TW'(cf_s1[ci(0, 1)]);
		uc = TW'(cf_s1[ci(0, 2)]);
		ud = TW'(cf_s1[ci(0, 3)]);
		va = TW'(cf_s1[ci(1, 0)]);
		vb = TW'(cf_s1[ci(1, 1)]);
		vc = TW'(cf_s1[ci(1, 2)]);
		vd = TW'(cf_s1[ci(1, 3)]);
		aa = p3_s1[0];
		ba = p3_s1[1];
		ac = p3_s1[2];
		bc = p3_s1[3];
		cb = p3_s1[4];
		db = p3_s1[5];
		cd = p3_s1[6];
		dd = p3_s1[7];
		for (int r = 0; r < 3; r++) begin
			for (int j = 0; j < 3; j++) begin
				t_c[r][j] = '0;
			end
		end
		unique case (sel_s1)
			4'd0: begin
				t_c[0] = '{aa, ba, vb}; t_c[1] = '{uc, ud, '0}; t_c[2] = '{ac, bc, vd};
			end
			4'd1: begin
				t_c[0] = '{ud, uc, '0}; t_c[1] = '{ba, aa, vb}; t_c[2] = '{bc, ac, vd};
			end
			4'd2: begin
				t_c[0] = '{aa, vb, ba}; t_c[1] = '{ac, vd, bc}; t_c[2] = '{uc, '0, ud};
			end
			4'd3: begin
				t_c[0] = '{va, cb, db}; t_c[1] = '{'0, ua, ub}; t_c[2] = '{vc, cd, dd};
			end
			4'd4: begin
				t_c[0] = '{ua, '0, ub}; t_c[1] = '{cb, va, db}; t_c[2] = '{cd, vc, dd};
			end
			4'd5: begin
				t_c[0] = '{va, db, cb}; t_c[1] = '{vc, dd, cd}; t_c[2] = '{'0, ub, ua};
			end
			4'd6: begin
				t_c[0] = '{dd, cd, vc}; t_c[1] = '{ub, ua, '0}; t_c[2] = '{db, cb, va};
			end
			4'd7: begin
				t_c[0] = '{ua, ub, '0}; t_c[1] = '{cd, dd, vc}; t_c[2] = '{cb, db, va};
			end
			4'd8: begin
				t_c[0] = '{dd, vc, cd}; t_c[1] = '{db, va, cb}; t_c[2] = '{ub, '0, ua};
			end
			4'd9: begin
				t_c[0] = '{vd, bc, ac}; t_c[1] = '{'0, ud, uc}; t_c[2] = '{vb, ba, aa};
			end
			4'd10: begin
				t_c[0] = '{ud, '0, uc}; t_c[1] = '{bc, vd, ac}; t_c[2] = '{ba, vb, aa};
			end
			4'd11: begin
				t_c[0] = '{vd, ac, bc}; t_c[1] = '{vb, aa, ba}; t_c[2] = '{'0, uc, ud};
			end
			default: ;
		endcase
	end

	logic [1:0]              mode_s2;
	logic                    bad_s2;
	logic signed [SB-1:0]    x_s2 [5];
	logic signed [CB-1:0]    k5_s2 [4];
	logic signed [TW-1:0]    t_s2 [3][3];
	logic signed [TW-1:0]    m4_s2 [4][4];
	logic signed [TW-1:0]    e5_s2 [8];

	always_ff @(posedge clk) begin
		if (en2) begin
			mode_s2  <= mode_s1;
			bad_s2   <= bad_s1;
			x_s2     <= x_s1;
			k5_s2[0] <= cf_s1[ci(3, 0)];
			k5_s2[1] <= cf_s1[ci(4, 0)];
			k5_s2[2] <= cf_s1[ci(3, 2)];
			k5_s2[3] <= cf_s1[ci(4, 2)];
			t_s2     <= t_c;
			m4_s2    <= m4_s1;
			e5_s2    <= e5_s1;
		end
	end

	// ---------------------------------------------------------------
	// Stage 3: scale the layout for five channels and assemble the matrix.
	// ---------------------------------------------------------------
	logic signed [MW-1:0] m_c [5][5];

	always_comb begin
		for (int r = 0; r < 5; r++) begin
			for (int j = 0; j < 5; j++) begin
				m_c[r][j] = '0;
			end
		end
		unique case (mode_s2)
			mcdm_pkg::MODE_4CH: begin
				for (int r = 0; r < 4; r++) begin
					for (int j = 0; j < 4; j++) begin
						m_c[r][j] = MW'(m4_s2[r][j]);
					end
				end
			end
			mcdm_pkg::MODE_5CH: begin
				for (int j = 0; j < 3; j++) begin
					m_c[0][j] = rct(k5_s2[0], t_s2[0][j]);
					m_c[1][j] = rct(k5_s2[1], t_s2[1][j]);
					m_c[2][j] = MW'(t_s2[2][j]);
					m_c[3][j] = rct(k5_s2[2], t_s2[0][j]);
					m_c[4][j] = rct(k5_s2[3], t_s2[1][j]);
				end
				m_c[0][3] = MW'(e5_s2[0]);
				m_c[0][4] = MW'(e5_s2[1]);
				m_c[1][3] = MW'(e5_s2[2]);
				m_c[1][4] = MW'(e5_s2[3]);
				m_c[3][3] = MW'(e5_s2[4]);
				m_c[3][4] = MW'(e5_s2[5]);
				m_c[4][3] = MW'(e5_s2[6]);
				m_c[4][4] = MW'(e5_s2[7]);
			end
			default: begin
				for (int r = 0; r < 3; r++) begin
					for (int j = 0; j < 3; j++) begin
						m_c[r][j] = MW'(t_s2[r][j]);
					end
				end
			end
		endcase
	end

	logic [1:0]              mode_s3;
	logic                    bad_s3;
	logic signed [SB-1:0]    x_s3 [5];
	logic signed [MW-1:0]    m_s3 [5][5];

	always_ff @(posedge clk) begin
		if (en3) begin
			mode_s3 <= mode_s2;
			bad_s3  <= bad_s2;
			x_s3    <= x_s2;
			m_s3    <= m_c;
		end
	end

	// ---------------------------------------------------------------
	// Stage 4: entry-by-line products.
	// ---------------------------------------------------------------
	logic [1:0]              mode_s4;
	logic                    bad_s4;
	logic signed [SB-1:0]    x_s4 [5];
	logic signed [PW-1:0]    pr_s4 [5][5];

	always_ff @(posedge clk) begin
		if (en4) begin
			mode_s4 <= mode_s3;
			bad_s4  <= bad_s3;
			x_s4    <= x_s3;
			for (int r = 0; r < 5; r++) begin
				for (int j = 0; j < 5; j++) begin
					pr_s4[r][j] <= m_s3[r][j] * x_s3[j];
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Stage 5: row sums, rounded to the line format.
	// ---------------------------------------------------------------
	logic signed [AW-1:0] acc_c [5];

	always_comb begin
		for (int r = 0; r < 5; r++) begin
			acc_c[r] = HALF_A + AW'(pr_s4[r][0]) + AW'(pr_s4[r][1]) + AW'(pr_s4[r][2])
				+ AW'(pr_s4[r][3]) + AW'(pr_s4[r][4]);
		end
	end

	logic [1:0]              mode_s5;
	logic                    bad_s5;
	logic signed [SB-1:0]    x_s5 [5];
	logic signed [RW-1:0]    r_s5 [5];

	always_ff @(posedge clk) begin
		if (en5) begin
			mode_s5 <= mode_s4;
			bad_s5  <= bad_s4;
			x_s5    <= x_s4;
			for (int r = 0; r < 5; r++) begin
				r_s5[r] <= acc_c[r][AW-1:FRAC];
			end
		end
	end

	// ---------------------------------------------------------------
	// Stage 6 (output register): saturate, or pass the lines through
	// when the selector is undefined.
	// ---------------------------------------------------------------
	logic signed [SB-1:0] y_c [5];

	always_comb begin
		for (int r = 0; r < 5; r++) begin
			if (bad_s5) begin
				// Undefined selector occurs only in three and five channel modes.
				if (r < 3 || mode_s5 == mcdm_pkg::MODE_5CH) begin
					y_c[r] = x_s5[r];
				end else begin
					y_c[r] = '0;
				end
			end else if (r_s5[r] > SAT_HI) begin
				y_c[r] = SAT_HI[SB-1:0];
			end else if (r_s5[r] < SAT_LO) begin
				y_c[r] = SAT_LO[SB-1:0];
			end else begin
				y_c[r] = r_s5[r][SB-1:0];
			end
		end
	end

	logic [1:0]              mode_s6;
	logic                    bad_s6;
	logic [SB-1:0]           y_s6 [5];

	always_ff @(posedge clk) begin
		if (en6) begin
			mode_s6 <= mode_s5;
			bad_s6  <= bad_s5;
			for (int r = 0; r < 5; r++) begin
				y_s6[r] <= y_c[r];
			end
		end
	end

	always_comb begin
		m_tdata = '0;
		for (int r = 0; r < 5; r++) begin
			m_tdata[r*SB +: SB] = y_s6[r];
		end
	end

	assign m_tvalid   = v_s6;
	assign m_tuser[0] = bad_s6;

`ifndef SYNTHESIS
	// The four-channel form never flags an undefined selector.
	a_bad_not_4ch: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s6 && bad_s6) |-> (mode_s6 != mcdm_pkg::MODE_4CH))
		else $error("undefined selector flagged in four channel mode");

	// A coefficient load never creates a result in flight.
	a_load_no_item: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser[0] == mcdm_pkg::FUNC_LOAD) |=> !v_s1)
		else $error("load request entered the pipeline");

	// Three-channel results leave the upper channels at zero.
	a_3ch_upper_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s6 && mode_s6 == mcdm_pkg::MODE_3CH) |-> (y_s6[3] == '0 && y_s6[4] == '0))
		else $error("unused channel nonzero in three channel mode");

	// Stage 5, when it holds a result that cannot move, keeps it.
	a_stall_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && !en5) |=> v_s5)
		else $error("stalled stage lost its result");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/mcdm_checker.sv =====
// Checker of the multichannel dematrix: watches the APB, input and output channels.
// Predicts each mixed line from its own coefficient store and compares results in order.
// Depends on mcdm_pkg only.
`default_nettype none
module mcdm_checker (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [2:0]   paddr,
	input  wire logic [31:0]  pwdata,
	input  wire logic         pready,
	input  wire logic         s_tvalid,
	input  wire logic         s_tready,
	input  wire logic [143:0] s_tdata,
	input  wire logic [0:0]   s_tuser,
	input  wire logic         m_tvalid,
	input  wire logic         m_tready,
	input  wire logic [119:0] m_tdata,
	input  wire logic [0:0]   m_tuser,
	output int                mismatches,
	output int                pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint SAT_HI = 64'sd8388607;
	localparam longint SAT_LO = -64'sd8388608;

	typedef struct packed {
		logic [119:0] lines;
		logic         bad;
	} mixed_t;

	mixed_t     mixed_q[$];
	longint     coef_mem[20];
	logic [2:0] cur_count;
	logic [3:0] cur_select;
	longint     tri_m[3][3];
	longint     mat[5][5];

	function automatic longint rnd_mul(longint x, longint y);
		return (x * y + 64'sd4096) >>> 13;
	endfunction

	function automatic longint cf(int set, int k);
		return coef_mem[set * 4 + k];
	endfunction

	function automatic void tri_row(int r, longint x, longint y, longint z);
		tri_m[r][0] = x;
		tri_m[r][1] = y;
		tri_m[r][2] = z;
	endfunction

	// Builds one of the twelve three-channel layouts; returns 0 for an undefined selector.
	function automatic bit build_tri(logic [3:0] sel);
		longint ua, ub, uc, ud, va, vb, vc, vd;
		ua = cf(0, 0); ub = cf(0, 1); uc = cf(0, 2); ud = cf(0, 3);
		va = cf(1, 0); vb = cf(1, 1); vc = cf(1, 2); vd = cf(1, 3);
		case (sel)
			4'd0: begin
				tri_row(0, rnd_mul(ua, va), rnd_mul(ub, va), vb);
				tri_row(1, uc, ud, 0);
				tri_row(2, rnd_mul(ua, vc), rnd_mul(ub, vc), vd);
			end
			4'd1: begin
				tri_row(0, ud, uc, 0);
				tri_row(1, rnd_mul(ub, va), rnd_mul(ua, va), vb);
				tri_row(2, rnd_mul(ub, vc), rnd_mul(ua, vc), vd);
			end
			4'd2: begin
				tri_row(0, rnd_mul(ua, va), vb, rnd_mul(ub, va));
				tri_row(1, rnd_mul(ua, vc), vd, rnd_mul(ub, vc));
				tri_row(2, uc, 0, ud);
			end
			4'd3: begin
				tri_row(0, va, rnd_mul(uc, vb), rnd_mul(ud, vb));
				tri_row(1, 0, ua, ub);
				tri_row(2, vc, rnd_mul(uc, vd), rnd_mul(ud, vd));
			end
			4'd4: begin
				tri_row(0, ua, 0, ub);
				tri_row(1, rnd_mul(uc, vb), va, rnd_mul(ud, vb));
				tri_row(2, rnd_mul(uc, vd), vc, rnd_mul(ud, vd));
			end
			4'd5: begin
				tri_row(0, va, rnd_mul(ud, vb), rnd_mul(uc, vb));
				tri_row(1, vc, rnd_mul(ud, vd), rnd_mul(uc, vd));
				tri_row(2, 0, ub, ua);
			end
			4'd6: begin
				tri_row(0, rnd_mul(ud, vd), rnd_mul(uc, vd), vc);
				tri_row(1, ub, ua, 0);
				tri_row(2, rnd_mul(ud, vb), rnd_mul(uc, vb), va);
			end
			4'd7: begin
				tri_row(0, ua, ub, 0);
				tri_row(1, rnd_mul(uc, vd), rnd_mul(ud, vd), vc);
				tri_row(2, rnd_mul(uc, vb), rnd_mul(ud, vb), va);
			end
			4'd8: begin
				tri_row(0, rnd_mul(ud, vd), vc, rnd_mul(uc, vd));
				tri_row(1, rnd_mul(ud, vb), va, rnd_mul(uc, vb));
				tri_row(2, ub, 0, ua);
			end
			4'd9: begin
				tri_row(0, vd, rnd_mul(ub, vc), rnd_mul(ua, vc));
				tri_row(1, 0, ud, uc);
				tri_row(2, vb, rnd_mul(ub, va), rnd_mul(ua, va));
			end
			4'd10: begin
				tri_row(0, ud, 0, uc);
				tri_row(1, rnd_mul(ub, vc), vd, rnd_mul(ua, vc));
				tri_row(2, rnd_mul(ub, va), vb, rnd_mul(ua, va));
			end
			4'd11: begin
				tri_row(0, vd, rnd_mul(ua, vc), rnd_mul(ub, vc));
				tri_row(1, vb, rnd_mul(ua, va), rnd_mul(ub, va));
				tri_row(2, 0, uc, ud);
			end
			default: return 1'b0;
		endcase
		return 1'b1;
	endfunction

	function automatic void build_quad();
		int lo, pair;
		for (int r = 0; r < 4; r++) begin
			lo = (r & 1) ? 2 : 0;
			for (int j = 0; j < 4; j++) begin
				pair = j >> 1;
				mat[r][j] = rnd_mul(cf(pair, lo + (j & 1)),
					cf(2 + (r & 1), (r >> 1) ? 2 + pair : pair));
			end
		end
	endfunction

	function automatic void build_penta();
		for (int j = 0; j < 3; j++) begin
			mat[0][j] = rnd_mul(cf(3, 0), tri_m[0][j]);
			mat[1][j] = rnd_mul(cf(4, 0), tri_m[1][j]);
			mat[2][j] = tri_m[2][j];
			mat[3][j] = rnd_mul(cf(3, 2), tri_m[0][j]);
			mat[4][j] = rnd_mul(cf(4, 2), tri_m[1][j]);
		end
		mat[0][3] = rnd_mul(cf(3, 1), cf(2, 0)); mat[0][4] = rnd_mul(cf(3, 1), cf(2, 1));
		mat[1][3] = rnd_mul(cf(4, 1), cf(2, 2)); mat[1][4] = rnd_mul(cf(4, 1), cf(2, 3));
		mat[2][3] = 0;                           mat[2][4] = 0;
		mat[3][3] = rnd_mul(cf(3, 3), cf(2, 0)); mat[3][4] = rnd_mul(cf(3, 3), cf(2, 1));
		mat[4][3] = rnd_mul(cf(4, 3), cf(2, 2)); mat[4][4] = rnd_mul(cf(4, 3), cf(2, 3));
	endfunction

	// Mixes one line vector with the current channel count and layout.
	function automatic mixed_t mix_line(logic [143:0] d);
		mixed_t res;
		longint x[5];
		longint acc;
		int     n;
		bit     defined;
		res = '0;
		n = (cur_count < 3) ? 3 : (cur_count > 5) ? 5 : int'(cur_count);
		for (int i = 0; i < 5; i++) begin
			x[i] = longint'($signed(d[21 + 24 * i +: 24]));
			for (int j = 0; j < 5; j++)
				mat[i][j] = 0;
		end
		defined = 1'b1;
		if (n == 4) begin
			build_quad();
		end else begin
			defined = build_tri(cur_select);
			if (defined && n == 3) begin
				for (int i = 0; i < 3; i++)
					for (int j = 0; j < 3; j++)
						mat[i][j] = tri_m[i][j];
			end else if (defined) begin
				build_penta();
			end
		end
		res.bad = !defined;
		for (int i = 0; i < n; i++) begin
			if (!defined) begin
				acc = x[i];
			end else begin
				acc = 0;
				for (int j = 0; j < n; j++)
					acc += mat[i][j] * x[j];
				acc = (acc + 64'sd4096) >>> 13;
				if (acc > SAT_HI)
					acc = SAT_HI;
				else if (acc < SAT_LO)
					acc = SAT_LO;
			end
			res.lines[24 * i +: 24] = acc[23:0];
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		mixed_t want;
		if (!arst_n) begin
			mixed_q.delete();
			foreach (coef_mem[k])
				coef_mem[k] = 0;
			cur_count = 3'd3;
			cur_select = 4'd0;
			mismatches = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == mcdm_pkg::REG_CHANNEL_COUNT)
					cur_count = pwdata[2:0];
				else
					cur_select = pwdata[3:0];
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser[0] == mcdm_pkg::FUNC_LINE)
					mixed_q.push_back(mix_line(s_tdata));
				else if (s_tdata[2:0] < 3'd5)
					coef_mem[s_tdata[2:0] * 4 + s_tdata[4:3]] =
						longint'($signed(s_tdata[20:5]));
			end
			if (m_tvalid && m_tready) begin
				if (mixed_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%t: unexpected result %h flag %b", $realtime, m_tdata,
							m_tuser[0]);
				end else begin
					want = mixed_q.pop_front();
					for (int i = 0; i < 5; i++) begin
						if (m_tdata[24 * i +: 24] !== want.lines[24 * i +: 24]) begin
							mismatches++;
							if (mismatches <= 10)
								$display("%t: mixed_ch%0d expected %h got %h", $realtime, i,
									want.lines[24 * i +: 24], m_tdata[24 * i +: 24]);
						end
					end
					if (m_tuser[0] !== want.bad) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%t: bad_select expected %b got %b", $realtime,
								want.bad, m_tuser[0]);
					end
				end
			end
		end
		pending = mixed_q.size();
	end

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Testbench top of the multichannel dematrix: clock, reset, stimulus and verdict.
// Depends on mcdm_pkg, multichannel_dematrix and mcdm_checker.
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 400;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         psel = 1'b0;
	logic         penable = 1'b0;
	logic         pwrite = 1'b0;
	logic [2:0]   paddr = '0;
	logic [31:0]  pwdata = '0;
	logic [31:0]  prdata;
	logic         pready;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	// set_index, coef_pick, coef_value, line_ch0 .. line_ch4, zero pad
	logic [143:0] s_tdata = '0;
	// func
	logic [0:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	// mixed_ch0 .. mixed_ch4, zero pad
	logic [119:0] m_tdata;
	// bad_select
	logic [0:0]   m_tuser;

	int mismatches;
	int pending;
	int line_reqs = 0;
	int load_reqs = 0;
	int idle_cycles = 0;
	bit tx_idle = 1'b1;
	bit rx_idle = 1'b1;
	int rx_wait = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	multichannel_dematrix i_dut (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.s_tvalid, .s_tready, .s_tdata, .s_tuser, .m_tvalid, .m_tready, .m_tdata, .m_tuser
	);

	mcdm_checker i_checker (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
		.s_tvalid, .s_tready, .s_tdata, .s_tuser, .m_tvalid, .m_tready, .m_tdata, .m_tuser,
		.mismatches, .pending
	);

	// After every result it takes, the receiver draws a random stall length while rx_idle is set, and none otherwise.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				rx_wait = rx_idle ? $urandom_range(0, 4) : 0;
			else if (rx_wait > 0)
				rx_wait--;
			m_tready <= (rx_wait == 0);
		end
	end

	// The watchdog ends a run in which no request or result moves for too long.
	always @(posedge clk) begin
		if (s_tvalid && s_tready || m_tvalid && m_tready || psel)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Watchdog expired with %0d results outstanding", pending);
			$display("Test completed with failures");
			$finish;
		end
	end

	// Register write: setup cycle, then access cycle, then the bus returns to idle;
	// pready is always high.
	task automatic write_reg(logic reg_idx, logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// Sends one request; while tx_idle is set, the sender first idles for a random gap that may be empty.
	task automatic send_req(logic kind, logic [143:0] body);
		int gap;
		gap = tx_idle ? $urandom_range(0, 4) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= body;
		do @(posedge clk); while (!s_tready);
		if (kind == mcdm_pkg::FUNC_LINE)
			line_reqs++;
		else
			load_reqs++;
	endtask

	task automatic send_load(logic [2:0] set, logic [1:0] pick, logic [15:0] value);
		send_req(mcdm_pkg::FUNC_LOAD, {123'b0, value, pick, set});
	endtask

	task automatic send_line(logic [23:0] c0, logic [23:0] c1, logic [23:0] c2,
			logic [23:0] c3, logic [23:0] c4);
		// The coefficient fields of a line request carry random noise.
		send_req(mcdm_pkg::FUNC_LINE, {3'b0, c4, c3, c2, c1, c0, 21'($urandom)});
	endtask

	// Lowers valid, waits until every predicted result has arrived, then lets the
	// six-stage pipeline settle so that a following register write finds it idle.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic logic [23:0] rand_line();
		case ($urandom_range(0, 9))
			0: return 24'h7fffff;
			1: return 24'h800000;
			2: return 24'h000000;
			default: return 24'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] rand_coef();
		case ($urandom_range(0, 9))
			0: return 16'h7fff;
			1: return 16'h8000;
			2, 3, 4, 5: return 16'($signed($urandom_range(0, 16384)) - 8192);
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		logic [2:0] count;
		logic [3:0] sel;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: coefficient extremes, loads to sets that do not exist, and
		// lines at full scale in the reset setting (three channels, layout zero).
		send_load(3'd0, 2'd0, 16'h7fff);
		send_load(3'd1, 2'd0, 16'h8000);
		send_load(3'd0, 2'd3, 16'h2000);
		send_load(3'd1, 2'd3, 16'hffff);
		send_load(3'd5, 2'd0, 16'h1234);
		send_load(3'd7, 2'd3, 16'hffff);
		send_line(24'h7fffff, 24'h7fffff, 24'h7fffff, 24'h7fffff, 24'h7fffff);
		send_line(24'h800000, 24'h800000, 24'h800000, 24'h800000, 24'h800000);
		send_line(24'h000000, 24'h7fffff, 24'h800000, 24'h000001, 24'hffffff);
		drain();
		// Undefined layout in five-channel mode passes the lines through.
		write_reg(mcdm_pkg::REG_CHANNEL_COUNT, 32'd5);
		write_reg(mcdm_pkg::REG_MATRIX_SELECT, 32'd15);
		send_line(24'h7fffff, 24'h800000, 24'h123456, 24'h654321, 24'h800001);
		drain();
		// Four-channel mode ignores the selector; loads into sets two and three matter.
		write_reg(mcdm_pkg::REG_CHANNEL_COUNT, 32'd4);
		send_load(3'd2, 2'd0, 16'h7fff);
		send_load(3'd3, 2'd2, 16'h8000);
		send_load(3'd4, 2'd1, 16'h4000);
		send_line(24'h7fffff, 24'h800000, 24'h7fffff, 24'h800000, 24'h7fffff);
		send_line(24'h800000, 24'h800000, 24'h800000, 24'h800000, 24'h000000);
		drain();

		// Random part: sixteen settings that visit every selector value, all three
		// channel counts, and out-of-range counts that the block clamps.
		for (int p = 0; p < 16; p++) begin
			count = (p == 14) ? 3'd0 : (p == 15) ? 3'd7 : (p == 13) ? 3'd2 :
				3'(3 + p % 3);
			sel = 4'((p * 5) % 16);
			write_reg(mcdm_pkg::REG_CHANNEL_COUNT, {29'($urandom), count});
			write_reg(mcdm_pkg::REG_MATRIX_SELECT, {28'($urandom), sel});
			tx_idle = (p % 4 != 3);
			rx_idle = (p % 4 != 1);
			// Each setting starts with a fresh coefficient set, then mixes loads
			// and lines so that coefficient changes land between lines too.
			for (int k = 0; k < 20; k++)
				send_load(3'(k / 4), 2'(k % 4), rand_coef());
			for (int k = 0; k < 50; k++) begin
				if ($urandom_range(0, 9) < 2)
					send_load(3'($urandom_range(0, 7)), 2'($urandom), rand_coef());
				else
					send_line(rand_line(), rand_line(), rand_line(), rand_line(),
						rand_line());
			end
			drain();
		end

		$display("Covered %0d line requests and %0d coefficient loads", line_reqs, load_reqs);
		$display("over channel counts 0, 2, 3, 4, 5 and 7 and all sixteen layout selectors");
		if (mismatches == 0 && pending == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
`default_nettype wire
